FILE: hdl/sts_pkg.sv
// sts_pkg: result kinds, field widths and keyword lookup for the token scanner.
// No dependencies.
`timescale 1ns / 1ps
package sts_pkg;

  localparam int KIND_W = 6;
  localparam int BYTE_W = 8;
  localparam int MANT_W = 64;
  localparam int FRAC_W = 6;
  localparam int FRAC_MAX = 62;
  localparam int HEAD_BYTES = 8;

  localparam int DEF_WORD_KEEP   = 63;
  localparam int DEF_STRING_KEEP = 255;

  localparam logic [KIND_W-1:0] K_EOF    = 6'd0;
  localparam logic [KIND_W-1:0] K_NUMBER = 6'd1;
  localparam logic [KIND_W-1:0] K_STRING = 6'd2;
  localparam logic [KIND_W-1:0] K_IDENT  = 6'd3;
  localparam logic [KIND_W-1:0] K_LET    = 6'd4;
  localparam logic [KIND_W-1:0] K_FUNC   = 6'd5;
  localparam logic [KIND_W-1:0] K_RETURN = 6'd6;
  localparam logic [KIND_W-1:0] K_IF     = 6'd7;
  localparam logic [KIND_W-1:0] K_ELSE   = 6'd8;
  localparam logic [KIND_W-1:0] K_WHILE  = 6'd9;
  localparam logic [KIND_W-1:0] K_TRY    = 6'd10;
  localparam logic [KIND_W-1:0] K_CATCH  = 6'd11;
  localparam logic [KIND_W-1:0] K_FINALLY = 6'd12;
  localparam logic [KIND_W-1:0] K_THROW  = 6'd13;
  localparam logic [KIND_W-1:0] K_TRUE   = 6'd14;
  localparam logic [KIND_W-1:0] K_FALSE  = 6'd15;
  localparam logic [KIND_W-1:0] K_PLUS   = 6'd16;
  localparam logic [KIND_W-1:0] K_MINUS  = 6'd17;
  localparam logic [KIND_W-1:0] K_STAR   = 6'd18;
  localparam logic [KIND_W-1:0] K_SLASH  = 6'd19;
  localparam logic [KIND_W-1:0] K_SEMI   = 6'd20;
  localparam logic [KIND_W-1:0] K_LPAR   = 6'd21;
  localparam logic [KIND_W-1:0] K_RPAR   = 6'd22;
  localparam logic [KIND_W-1:0] K_LBRACE = 6'd23;
  localparam logic [KIND_W-1:0] K_RBRACE = 6'd24;
  localparam logic [KIND_W-1:0] K_LBRACK = 6'd25;
  localparam logic [KIND_W-1:0] K_RBRACK = 6'd26;
  localparam logic [KIND_W-1:0] K_COMMA  = 6'd27;
  localparam logic [KIND_W-1:0] K_COLON  = 6'd28;
  localparam logic [KIND_W-1:0] K_DOT    = 6'd29;
  localparam logic [KIND_W-1:0] K_ASSIGN = 6'd30;
  localparam logic [KIND_W-1:0] K_ANDAND = 6'd38;
  localparam logic [KIND_W-1:0] K_OROR   = 6'd39;
  localparam logic [KIND_W-1:0] K_BYTE   = 6'd40;
  localparam logic [KIND_W-1:0] K_UNTERM = 6'd41;
  localparam logic [KIND_W-1:0] K_UNEXP  = 6'd42;

  // pending operator codes
  localparam logic [2:0] P_NONE = 3'd0;
  localparam logic [2:0] P_EQ   = 3'd1;
  localparam logic [2:0] P_NOT  = 3'd2;
  localparam logic [2:0] P_LT   = 3'd3;
  localparam logic [2:0] P_GT   = 3'd4;
  localparam logic [2:0] P_AMP  = 3'd5;
  localparam logic [2:0] P_BAR  = 3'd6;
  localparam logic [2:0] P_DIV  = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] lbyte;
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    logic              last;
  } res_t;

  function automatic res_t mk_res(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] lbyte,
                                  logic [MANT_W-1:0] mant, logic [FRAC_W-1:0] frac);
    res_t r;
    r.kind  = kind;
    r.lbyte = lbyte;
    r.mant  = mant;
    r.frac  = frac;
    r.last  = 1'b0;
    return r;
  endfunction

  // head is little-endian packed; len is 15 when more than 8 bytes were kept
  function automatic logic [KIND_W-1:0] kw_kind(logic [63:0] head, logic [3:0] len);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    if (len == 4'd3 && head == 64'("tel"))           k = K_LET;
    if (len == 4'd8 && head == 64'("noitcnuf"))      k = K_FUNC;
    if (len == 4'd6 && head == 64'("nruter"))        k = K_RETURN;
    if (len == 4'd2 && head == 64'("fi"))            k = K_IF;
    if (len == 4'd4 && head == 64'("esle"))          k = K_ELSE;
    if (len == 4'd5 && head == 64'("elihw"))         k = K_WHILE;
    if (len == 4'd3 && head == 64'("yrt"))           k = K_TRY;
    if (len == 4'd5 && head == 64'("hctac"))         k = K_CATCH;
    if (len == 4'd7 && head == 64'("yllanif"))       k = K_FINALLY;
    if (len == 4'd5 && head == 64'("worht"))         k = K_THROW;
    if (len == 4'd4 && head == 64'("eurt"))          k = K_TRUE;
    if (len == 4'd5 && head == 64'("eslaf"))         k = K_FALSE;
    return k;
  endfunction

endpackage

FILE: hdl/script_token_scanner.sv
// script_token_scanner: byte-serial lexer, one source byte per word.
// Depends on sts_pkg.
`timescale 1ns / 1ps
// One source byte is accepted per cycle while in_tready is high. Each accepted
// byte is decoded from the input register in the cycle after it is accepted, and
// its zero, one or two results enter a six-entry output queue for the output port.
// Bytes that close a token and start another give two results, which the queue
// holds until the output port takes them in turn, and in_tready drops only
// when more than two results are waiting. Identifier and string bytes come out
// as lexeme-byte words (kind 40) ahead of their token; a keyword token means the
// consumer drops those bytes. tlast marks the final result of one input byte.
module script_token_scanner
  import sts_pkg::*;
#(
  parameter int WORD_KEEP   = DEF_WORD_KEEP,
  parameter int STRING_KEEP = DEF_STRING_KEEP
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] lexeme_byte, [71:8] mantissa, [77:72] frac_digits
  output logic [5:0]  out_tuser,  // [5:0] kind
  output logic        out_tlast
);

  localparam int KEEP_MAX = (WORD_KEEP > STRING_KEEP) ? WORD_KEEP : STRING_KEEP;
  localparam int KEPT_W   = $clog2(KEEP_MAX + 1);
  localparam int QDEPTH   = 6;
  localparam int QCNT_W   = 3;

  typedef enum logic [2:0] {
    M_START, M_OP, M_COMMENT, M_NUM, M_WORD, M_STR
  } mode_t;

  mode_t               mode_r, mode_nxt, st_mode;
  logic [2:0]          pend_r, pend_nxt, st_pend;
  logic                qs_r, qs_nxt, st_qs;
  logic                esc_r, esc_nxt, st_esc;
  logic [KEPT_W-1:0]   kept_r, kept_nxt, st_kept;
  logic [63:0]         head_r, head_nxt, st_head;
  logic [MANT_W-1:0]   mant_r, mant_nxt, st_mant;
  logic [FRAC_W-1:0]   frac_r, frac_nxt, st_frac;
  logic [1:0]          dots_r, dots_nxt, st_dots;
  logic                halt_r, halt_nxt, st_halt;
  logic                st_emit;
  res_t                st_res;

  logic                vld_r;
  logic [7:0]          byte_r;
  logic [7:0]          c;
  logic [7:0]          sc;
  logic                is_dig, is_alp, is_spc;
  logic [MANT_W+3:0]   mul10;
  logic [3:0]          wlen;
  logic [KIND_W-1:0]   wkind;
  res_t                r0, r1;
  logic [1:0]          rn;

  res_t                q_r [QDEPTH];
  logic [QCNT_W-1:0]   cnt_r;
  logic                pop;
  logic [QCNT_W-1:0]   base;

  assign c      = byte_r;
  assign is_dig = (c >= "0") && (c <= "9");
  assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign is_spc = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  assign mul10  = {1'b0, mant_r, 3'b000} + {3'b000, mant_r, 1'b0} + (MANT_W+4)'(c - "0");
  assign wlen   = (kept_r > KEPT_W'(HEAD_BYTES)) ? 4'd15 : kept_r[3:0];
  assign wkind  = kw_kind(head_r, wlen);

  // effect of scanning c as the first byte of a token
  always_comb begin
    st_mode = M_START;
    st_pend = P_NONE;
    st_qs   = qs_r;
    st_esc  = esc_r;
    st_kept = kept_r;
    st_head = head_r;
    st_mant = mant_r;
    st_frac = frac_r;
    st_dots = dots_r;
    st_halt = halt_r;
    st_emit = 1'b0;
    st_res  = mk_res(K_EOF, '0, '0, '0);
    if (is_spc) begin
      st_mode = M_START;
    end else if (is_dig) begin
      st_mode = M_NUM;
      st_mant = MANT_W'(c - "0");
      st_frac = '0;
      st_dots = '0;
      st_kept = KEPT_W'(1);
    end else if (c == "\"" || c == "'") begin
      st_mode = M_STR;
      st_qs   = (c == "'");
      st_esc  = 1'b0;
      st_kept = '0;
    end else if (is_alp) begin
      st_mode = M_WORD;
      st_kept = KEPT_W'(1);
      st_head = 64'(c);
      st_emit = 1'b1;
      st_res  = mk_res(K_BYTE, c, '0, '0);
    end else begin
      st_emit = 1'b1;
      unique case (c)
        "+": st_res = mk_res(K_PLUS, '0, '0, '0);
        "-": st_res = mk_res(K_MINUS, '0, '0, '0);
        "*": st_res = mk_res(K_STAR, '0, '0, '0);
        ";": st_res = mk_res(K_SEMI, '0, '0, '0);
        "(": st_res = mk_res(K_LPAR, '0, '0, '0);
        ")": st_res = mk_res(K_RPAR, '0, '0, '0);
        "{": st_res = mk_res(K_LBRACE, '0, '0, '0);
        "}": st_res = mk_res(K_RBRACE, '0, '0, '0);
        "[": st_res = mk_res(K_LBRACK, '0, '0, '0);
        "]": st_res = mk_res(K_RBRACK, '0, '0, '0);
        ",": st_res = mk_res(K_COMMA, '0, '0, '0);
        ":": st_res = mk_res(K_COLON, '0, '0, '0);
        ".": st_res = mk_res(K_DOT, '0, '0, '0);
        "=": begin st_emit = 1'b0; st_pend = P_EQ;  st_mode = M_OP; end
        "!": begin st_emit = 1'b0; st_pend = P_NOT; st_mode = M_OP; end
        "<": begin st_emit = 1'b0; st_pend = P_LT;  st_mode = M_OP; end
        ">": begin st_emit = 1'b0; st_pend = P_GT;  st_mode = M_OP; end
        "&": begin st_emit = 1'b0; st_pend = P_AMP; st_mode = M_OP; end
        "|": begin st_emit = 1'b0; st_pend = P_BAR; st_mode = M_OP; end
        "/": begin st_emit = 1'b0; st_pend = P_DIV; st_mode = M_OP; end
        default: begin
          st_res  = mk_res(K_UNEXP, c, '0, '0);
          st_halt = 1'b1;
        end
      endcase
    end
  end

  // main decode of the registered byte
  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    qs_nxt   = qs_r;
    esc_nxt  = esc_r;
    kept_nxt = kept_r;
    head_nxt = head_r;
    mant_nxt = mant_r;
    frac_nxt = frac_r;
    dots_nxt = dots_r;
    halt_nxt = halt_r;
    r0 = mk_res(K_EOF, '0, '0, '0);
    r1 = mk_res(K_EOF, '0, '0, '0);
    rn = 2'd0;
    sc = c;
    if (vld_r) begin
      if (c == 8'd0) begin
        if (!halt_r) begin
          rn = 2'd1;
          unique case (mode_r)
            M_NUM: begin
              r0 = mk_res(K_NUMBER, '0, mant_r, frac_r);
              r1 = mk_res(K_EOF, '0, '0, '0);
              rn = 2'd2;
            end
            M_WORD: begin
              r0 = mk_res(wkind, '0, '0, '0);
              r1 = mk_res(K_EOF, '0, '0, '0);
              rn = 2'd2;
            end
            M_OP: begin
              if (pend_r == P_AMP || pend_r == P_BAR) begin
                r0 = mk_res(K_UNEXP, '0, '0, '0);
              end else begin
                r0 = mk_res((pend_r == P_DIV) ? K_SLASH :
                            K_ASSIGN + {2'b00, pend_r - 3'd1, 1'b0}, '0, '0, '0);
                r1 = mk_res(K_EOF, '0, '0, '0);
                rn = 2'd2;
              end
            end
            M_STR: r0 = mk_res(K_UNTERM, '0, '0, '0);
            default: r0 = mk_res(K_EOF, '0, '0, '0);
          endcase
        end
        mode_nxt = M_START;
        pend_nxt = P_NONE;
        qs_nxt   = 1'b0;
        esc_nxt  = 1'b0;
        kept_nxt = '0;
        head_nxt = '0;
        mant_nxt = '0;
        frac_nxt = '0;
        dots_nxt = '0;
        halt_nxt = 1'b0;
      end else if (!halt_r) begin
        unique case (mode_r)
          M_OP: begin
            if (pend_r == P_AMP || pend_r == P_BAR) begin
              mode_nxt = M_START;
              pend_nxt = P_NONE;
              rn = 2'd1;
              if (c == ((pend_r == P_AMP) ? "&" : "|")) begin
                r0 = mk_res((pend_r == P_AMP) ? K_ANDAND : K_OROR, '0, '0, '0);
              end else begin
                r0 = mk_res(K_UNEXP, c, '0, '0);
                halt_nxt = 1'b1;
              end
            end else if (pend_r == P_DIV && c == "/") begin
              mode_nxt = M_COMMENT;
              pend_nxt = P_NONE;
            end else if (pend_r != P_DIV && pend_r != P_NONE && c == "=") begin
              mode_nxt = M_START;
              pend_nxt = P_NONE;
              r0 = mk_res(K_ASSIGN + {2'b00, pend_r - 3'd1, 1'b0} + 6'd1, '0, '0, '0);
              rn = 2'd1;
            end else begin
              if (pend_r != P_NONE) begin
                r0 = mk_res((pend_r == P_DIV) ? K_SLASH :
                            K_ASSIGN + {2'b00, pend_r - 3'd1, 1'b0}, '0, '0, '0);
                rn = 2'd1;
              end
              mode_nxt = st_mode; pend_nxt = st_pend; qs_nxt = st_qs; esc_nxt = st_esc;
              kept_nxt = st_kept; head_nxt = st_head; mant_nxt = st_mant;
              frac_nxt = st_frac; dots_nxt = st_dots; halt_nxt = st_halt;
              if (st_emit) begin
                if (rn == 2'd0) r0 = st_res; else r1 = st_res;
                rn = rn + 2'd1;
              end
            end
          end
          M_COMMENT: begin
            if (c == 8'd10) mode_nxt = M_START;
          end
          M_NUM: begin
            if (is_dig) begin
              if (kept_r < KEPT_W'(WORD_KEEP)) begin
                kept_nxt = kept_r + KEPT_W'(1);
                if (dots_r == 2'd0 || (dots_r == 2'd1 && frac_r < FRAC_W'(FRAC_MAX))) begin
                  mant_nxt = (mul10[MANT_W+3:MANT_W] != 4'd0) ? '1 : mul10[MANT_W-1:0];
                  if (dots_r == 2'd1) frac_nxt = frac_r + FRAC_W'(1);
                end
              end
            end else if (c == ".") begin
              if (kept_r < KEPT_W'(WORD_KEEP)) begin
                kept_nxt = kept_r + KEPT_W'(1);
                if (dots_r < 2'd2) dots_nxt = dots_r + 2'd1;
              end
            end else begin
              r0 = mk_res(K_NUMBER, '0, mant_r, frac_r);
              rn = 2'd1;
              mode_nxt = st_mode; pend_nxt = st_pend; qs_nxt = st_qs; esc_nxt = st_esc;
              kept_nxt = st_kept; head_nxt = st_head; mant_nxt = st_mant;
              frac_nxt = st_frac; dots_nxt = st_dots; halt_nxt = st_halt;
              if (st_emit) begin
                r1 = st_res;
                rn = 2'd2;
              end
            end
          end
          M_WORD: begin
            if (is_alp || is_dig) begin
              if (kept_r < KEPT_W'(WORD_KEEP)) begin
                if (kept_r < KEPT_W'(HEAD_BYTES))
                  head_nxt = head_r | (64'(c) << {kept_r[2:0], 3'b000});
                kept_nxt = kept_r + KEPT_W'(1);
                r0 = mk_res(K_BYTE, c, '0, '0);
                rn = 2'd1;
              end
            end else begin
              r0 = mk_res(wkind, '0, '0, '0);
              rn = 2'd1;
              mode_nxt = st_mode; pend_nxt = st_pend; qs_nxt = st_qs; esc_nxt = st_esc;
              kept_nxt = st_kept; head_nxt = st_head; mant_nxt = st_mant;
              frac_nxt = st_frac; dots_nxt = st_dots; halt_nxt = st_halt;
              if (st_emit) begin
                r1 = st_res;
                rn = 2'd2;
              end
            end
          end
          M_STR: begin
            if (!esc_r && c == (qs_r ? "'" : "\"")) begin
              r0 = mk_res(K_STRING, '0, '0, '0);
              rn = 2'd1;
              mode_nxt = M_START;
            end else if (!esc_r && c == "\\") begin
              esc_nxt = 1'b1;
            end else begin
              esc_nxt = 1'b0;
              if (esc_r && c == "n") sc = 8'd10;
              else if (esc_r && c == "t") sc = 8'd9;
              if (kept_r < KEPT_W'(STRING_KEEP)) begin
                kept_nxt = kept_r + KEPT_W'(1);
                r0 = mk_res(K_BYTE, sc, '0, '0);
                rn = 2'd1;
              end
            end
          end
          default: begin
            mode_nxt = st_mode; pend_nxt = st_pend; qs_nxt = st_qs; esc_nxt = st_esc;
            kept_nxt = st_kept; head_nxt = st_head; mant_nxt = st_mant;
            frac_nxt = st_frac; dots_nxt = st_dots; halt_nxt = st_halt;
            if (st_emit) begin
              r0 = st_res;
              rn = 2'd1;
            end
          end
        endcase
      end
    end
    if (rn == 2'd1) r0.last = 1'b1;
    if (rn == 2'd2) r1.last = 1'b1;
  end

  assign in_tready  = (cnt_r <= QCNT_W'(2));
  assign pop        = out_tvalid && out_tready;
  assign base       = cnt_r - QCNT_W'(pop);
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {2'b00, q_r[0].frac, q_r[0].mant, q_r[0].lbyte};
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      mode_r <= M_START;
      pend_r <= P_NONE;
      qs_r   <= 1'b0;
      esc_r  <= 1'b0;
      kept_r <= '0;
      head_r <= '0;
      mant_r <= '0;
      frac_r <= '0;
      dots_r <= '0;
      halt_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      vld_r  <= in_tvalid && in_tready;
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      qs_r   <= qs_nxt;
      esc_r  <= esc_nxt;
      kept_r <= kept_nxt;
      head_r <= head_nxt;
      mant_r <= mant_nxt;
      frac_r <= frac_nxt;
      dots_r <= dots_nxt;
      halt_r <= halt_nxt;
      cnt_r  <= base + QCNT_W'(rn);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) byte_r <= in_tdata;
    for (int i = 0; i < QDEPTH; i++) begin
      if (rn != 2'd0 && QCNT_W'(i) == base) q_r[i] <= r0;
      else if (rn == 2'd2 && QCNT_W'(i) == base + QCNT_W'(1)) q_r[i] <= r1;
      else if (pop && i < QDEPTH - 1) q_r[i] <= q_r[(i < QDEPTH - 1) ? i + 1 : i];
    end
  end

endmodule

FILE: tb/sv/script_token_scanner_test.sv
// script_token_scanner_test: self-checking bench for the byte-serial token scanner.
// Predicts every result word from the source bytes sent; depends on sts_pkg and the RTL.
`timescale 1ns / 1ps
module script_token_scanner_test
  import sts_pkg::*;
();

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;

  typedef enum logic [2:0] {
    SM_START, SM_OP, SM_COMMENT, SM_NUM, SM_WORD, SM_STR
  } scan_mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  lbyte;
    logic [63:0] mant;
    logic [5:0]  frac;
    logic        last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [5:0] out_tuser;
  logic out_tlast;

  script_token_scanner dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // scanner state copy
  scan_mode_t mode;
  logic [2:0] pend;
  logic single_q, esc;
  int unsigned kept;
  logic [63:0] head, macc;
  int unsigned fracs, dots;
  logic halt;
  token_t tok_buf[2];
  int n_tok;

  logic [7:0] src_q[$];
  token_t tokens_q[$];
  int errors = 0;
  bit src_done = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  bit calm = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void put(logic [5:0] k, logic [7:0] b, logic [63:0] m, int unsigned f);
    if (n_tok < 2) begin
      tok_buf[n_tok] = '{kind: k, lbyte: b, mant: m, frac: f[5:0], last: 1'b0};
      n_tok++;
    end
  endfunction

  task automatic clear_scan();
    mode = SM_START; pend = P_NONE; single_q = 0; esc = 0; kept = 0;
    head = 0; macc = 0; fracs = 0; dots = 0; halt = 0;
  endtask

  function automatic void fail_char(logic [7:0] c);
    put(K_UNEXP, c, 0, 0);
    halt = 1; mode = SM_START; pend = P_NONE;
  endfunction

  task automatic word_add(logic [7:0] c);
    if (kept < DEF_WORD_KEEP) begin
      if (kept < 8) head[8*kept +: 8] = c;
      kept++;
      put(K_BYTE, c, 0, 0);
    end
  endtask

  task automatic word_close();
    logic [5:0] k;
    k = K_IDENT;
    case (kept)
      2: if (head == 64'h6669) k = K_IF;
      3: if (head == 64'h74656c) k = K_LET;
         else if (head == 64'h797274) k = K_TRY;
      4: if (head == 64'h65736c65) k = K_ELSE;
         else if (head == 64'h65757274) k = K_TRUE;
      5: if (head == 64'h656c696877) k = K_WHILE;
         else if (head == 64'h6863746163) k = K_CATCH;
         else if (head == 64'h776f726874) k = K_THROW;
         else if (head == 64'h65736c6166) k = K_FALSE;
      6: if (head == 64'h6e7275746572) k = K_RETURN;
      7: if (head == 64'h796c6c616e6966) k = K_FINALLY;
      8: if (head == 64'h6e6f6974636e7566) k = K_FUNC;
      default: ;
    endcase
    put(k, 0, 0, 0);
    mode = SM_START;
  endtask

  task automatic begin_tok(logic [7:0] c);
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return;
    if (is_digit(c)) begin
      mode = SM_NUM; macc = 64'(c - "0"); fracs = 0; dots = 0; kept = 1;
      return;
    end
    if (c == "\"" || c == "'") begin
      mode = SM_STR; single_q = (c == "'"); esc = 0; kept = 0;
      return;
    end
    if (is_alpha(c)) begin
      mode = SM_WORD; kept = 0; head = 0;
      word_add(c);
      return;
    end
    case (c)
      "+": put(K_PLUS, 0, 0, 0);
      "-": put(K_MINUS, 0, 0, 0);
      "*": put(K_STAR, 0, 0, 0);
      ";": put(K_SEMI, 0, 0, 0);
      "(": put(K_LPAR, 0, 0, 0);
      ")": put(K_RPAR, 0, 0, 0);
      "{": put(K_LBRACE, 0, 0, 0);
      "}": put(K_RBRACE, 0, 0, 0);
      "[": put(K_LBRACK, 0, 0, 0);
      "]": put(K_RBRACK, 0, 0, 0);
      ",": put(K_COMMA, 0, 0, 0);
      ":": put(K_COLON, 0, 0, 0);
      ".": put(K_DOT, 0, 0, 0);
      "=": begin pend = P_EQ; mode = SM_OP; end
      "!": begin pend = P_NOT; mode = SM_OP; end
      "<": begin pend = P_LT; mode = SM_OP; end
      ">": begin pend = P_GT; mode = SM_OP; end
      "&": begin pend = P_AMP; mode = SM_OP; end
      "|": begin pend = P_BAR; mode = SM_OP; end
      "/": begin pend = P_DIV; mode = SM_OP; end
      default: fail_char(c);
    endcase
  endtask

  // returns 1 when the lookahead byte was consumed by the operator
  function automatic bit op_close(logic [7:0] c);
    logic [2:0] p;
    logic [5:0] base;
    p = pend;
    pend = P_NONE;
    mode = SM_START;
    if (p >= P_EQ && p <= P_GT) begin
      base = 6'(K_ASSIGN + 2 * (p - P_EQ));
      if (c == "=") begin put(base + 6'd1, 0, 0, 0); return 1; end
      put(base, 0, 0, 0);
      return 0;
    end
    if (p == P_AMP || p == P_BAR) begin
      if (c == (p == P_AMP ? "&" : "|")) begin
        put(p == P_AMP ? K_ANDAND : K_OROR, 0, 0, 0);
        return 1;
      end
      fail_char(c);
      return 1;
    end
    if (p == P_DIV) begin
      if (c == "/") begin mode = SM_COMMENT; return 1; end
      put(K_SLASH, 0, 0, 0);
      return 0;
    end
    return 0;
  endfunction

  task automatic num_add(logic [7:0] c);
    logic [63:0] d;
    if (is_digit(c)) begin
      if (kept < DEF_WORD_KEEP) begin
        kept++;
        if (dots == 0 || (dots == 1 && fracs < FRAC_MAX)) begin
          d = 64'(c - "0");
          if (macc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) macc = '1;
          else macc = macc * 10 + d;
          if (dots == 1) fracs++;
        end
      end
    end else if (c == ".") begin
      if (kept < DEF_WORD_KEEP) begin
        kept++;
        if (dots < 2) dots++;
      end
    end else begin
      put(K_NUMBER, 0, macc, fracs);
      mode = SM_START;
      begin_tok(c);
    end
  endtask

  task automatic str_add(logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (esc) begin
      esc = 0;
      if (c == "n") v = 8'd10;
      else if (c == "t") v = 8'd9;
    end else if (c == (single_q ? "'" : "\"")) begin
      put(K_STRING, 0, 0, 0);
      mode = SM_START;
      return;
    end else if (c == "\\") begin
      esc = 1;
      return;
    end
    if (kept < DEF_STRING_KEEP) begin
      kept++;
      put(K_BYTE, v, 0, 0);
    end
  endtask

  task automatic predict_tokens(logic [7:0] c);
    bit bad;
    n_tok = 0;
    if (c == 8'd0) begin
      if (!halt) begin
        bad = 0;
        case (mode)
          SM_NUM: put(K_NUMBER, 0, macc, fracs);
          SM_WORD: word_close();
          SM_OP: begin void'(op_close(0)); bad = halt; end
          SM_STR: begin put(K_UNTERM, 0, 0, 0); bad = 1; end
          default: ;
        endcase
        if (!bad) put(K_EOF, 0, 0, 0);
      end
      clear_scan();
    end else if (!halt) begin
      case (mode)
        SM_OP: if (!op_close(c)) begin_tok(c);
        SM_COMMENT: if (c == 8'd10) mode = SM_START;
        SM_NUM: num_add(c);
        SM_WORD: if (is_alpha(c) || is_digit(c)) word_add(c);
                 else begin word_close(); begin_tok(c); end
        SM_STR: str_add(c);
        default: begin_tok(c);
      endcase
    end
    if (n_tok > 0) tok_buf[n_tok-1].last = 1'b1;
    for (int i = 0; i < n_tok; i++) tokens_q.push_back(tok_buf[i]);
  endtask

  // ---------------- stimulus text builders
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  task automatic push_random_token();
    string kws[12] = '{"let", "function", "return", "if", "else", "while", "try",
                       "catch", "finally", "throw", "true", "false"};
    string ops[24] = '{"+", "-", "*", "/", ";", "(", ")", "{", "}", "[", "]", ",",
                       ":", ".", "=", "==", "!", "!=", "<", "<=", ">", ">=", "&&", "||"};
    int n;
    case ($urandom_range(0, 9))
      0: push_text(kws[$urandom_range(0, 11)]);
      1, 2: begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 9);
        src_q.push_back(rand_alpha());
        for (int i = 1; i < n; i++)
          src_q.push_back($urandom_range(0, 3) == 0 ? 8'("0" + $urandom_range(0, 9))
                                                    : rand_alpha());
      end
      3: begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
        src_q.push_back(8'("0" + $urandom_range(0, 9)));
        for (int i = 1; i < n; i++)
          src_q.push_back($urandom_range(0, 7) == 0 ? 8'(".") : 8'("0" + $urandom_range(0, 9)));
      end
      4: begin
        logic [7:0] q;
        q = $urandom_range(0, 1) ? "'" : "\"";
        src_q.push_back(q);
        n = ($urandom_range(0, 20) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          logic [7:0] b;
          b = 8'($urandom_range(1, 255));
          if (b == q) b = "x";
          if (b == "\\") begin src_q.push_back(b); b = $urandom_range(0, 1) ? "n" : "t"; end
          src_q.push_back(b);
        end
        src_q.push_back(q);
      end
      5, 6: push_text(ops[$urandom_range(0, 23)]);
      7: begin
        push_text("//");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) src_q.push_back(8'("a" + $urandom_range(0, 25)));
        src_q.push_back(8'd10);
      end
      8: src_q.push_back($urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 13)));
      default: src_q.push_back(8'($urandom_range(1, 255)));
    endcase
    if ($urandom_range(0, 2) == 0) src_q.push_back(8'd32);
  endtask

  // ---------------- driver
  bit stall_in;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_tokens(in_tdata);
        void'(src_q.pop_front());
      end
      stall_in = !calm && ($urandom_range(0, 99) < 32);
      if (src_q.size() > 0 && !stall_in && !src_done) begin
        in_tvalid <= 1'b1;
        in_tdata <= src_q[0];
      end else if (!(in_tvalid && !in_tready)) begin
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom_range(0, 255));
      end
    end
  end

  // ---------------- monitor
  token_t got;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, lbyte: out_tdata[7:0], mant: out_tdata[71:8],
                frac: out_tdata[77:72], last: out_tlast};
        if (tokens_q.size() == 0) begin
          $error("unexpected word kind=%0d", got.kind);
          errors++;
        end else begin
          token_t e;
          e = tokens_q.pop_front();
          if (e.kind != got.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, got.kind); errors++;
          end
          if (e.lbyte != got.lbyte) begin
            $error("lexeme_byte: expected %0d, got %0d", e.lbyte, got.lbyte); errors++;
          end
          if (e.mant != got.mant) begin
            $error("mantissa: expected %0d, got %0d", e.mant, got.mant); errors++;
          end
          if (e.frac != got.frac) begin
            $error("frac_digits: expected %0d, got %0d", e.frac, got.frac); errors++;
          end
          if (e.last != got.last) begin
            $error("last: expected %0d, got %0d", e.last, got.last); errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
      end
      out_tready <= !(hold_req && !hold_done) && (calm || $urandom_range(0, 99) >= 32);
    end
  end

  // ---------------- watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("script_token_scanner_test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (src_q.size() > 0 || tokens_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    clear_scan();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: keywords, ops, numbers, escapes, errors, end-of-text cases
    push_text("let function return if else while try catch finally throw true false ");
    push_text("x_1 a==b!=c<=d>=e&&f||g<h>i=j!k/l//c\n+-*;()[]{},:.");
    push_text("3.14 1.2.3 99999999999999999999999 'a\\nb\\tc\\q' \"x'y\"");
    src_q.push_back(8'd0);
    push_text("0.12345678901234567890123456789012345678901234567890123456789012345");
    src_q.push_back(8'd0);
    push_text("a & b"); src_q.push_back(8'd0);
    push_text("|"); src_q.push_back(8'd0);
    push_text("\"open"); src_q.push_back(8'd0);
    push_text("#"); src_q.push_back(8'hff); src_q.push_back(8'd0);
    push_text("x<"); src_q.push_back(8'd0);
    push_text("7/"); src_q.push_back(8'd0);
    wait_drained();

    // sink holds off while bytes keep arriving
    hold_req = 1;
    repeat (40) push_random_token();
    wait (hold_done);
    hold_req = 0;
    wait_drained();

    // quiet stretch with no idling
    calm = 1;
    while (src_q.size() < 150) push_random_token();
    wait_drained();
    calm = 0;

    for (int i = 0; i < 550; ) begin
      int before_n;
      before_n = src_q.size();
      if ($urandom_range(0, 30) == 0) src_q.push_back(8'd0);
      else push_random_token();
      i += src_q.size() - before_n;
      if (src_q.size() > 16) while (src_q.size() > 4) @(posedge clk);
    end
    src_q.push_back(8'd0);
    wait_drained();
    src_done = 1;
    repeat (20) @(posedge clk);
    if (tokens_q.size() != 0) errors++;
    if (errors == 0) $display("script_token_scanner_test passed");
    else $display("script_token_scanner_test failed");
    $finish;
  end

endmodule
